[hdl/deq_pkg.sv]
// Shared types, codes and constants for the double-ended queue.
package deq_pkg;

  localparam int DEQ_DEPTH   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int POS_W       = 6;
  localparam int STAT_W      = 2;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam logic [MODE_W-1:0] MODE_CLEAR_STORE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WALK_FWD    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_WALK_REV    = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    word_t             value;
  } in_item_t;

  typedef struct packed {
    word_t             data_out;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INSERT,
    CELL_APPEND,
    CELL_REMOVE,
    CELL_TRIM,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    value;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

endpackage

[hdl/deq_cell.sv]
// One storage cell of the deque row: an entry and its occupied bit.
module deq_cell
  import deq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head,
  input  cell_ctrl_t ctrl,
  input  word_t      left_data,
  input  logic       left_occ,
  input  word_t      right_data,
  input  logic       right_occ,
  input  word_t      wrap_data,
  output word_t      data,
  output logic       occ,
  output logic       back
);

  assign back = occ && !right_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_LOAD:   occ <= head;
        CELL_INSERT: occ <= left_occ;
        CELL_APPEND: if (!occ && left_occ) occ <= 1'b1;
        CELL_REMOVE: occ <= right_occ;
        CELL_TRIM:   if (back) occ <= 1'b0;
        default:     occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_LOAD:      if (head) data <= ctrl.value;
      CELL_INSERT:    data <= left_data;
      CELL_APPEND:    if (!occ && left_occ) data <= ctrl.value;
      CELL_REMOVE:    data <= right_data;
      // back entry wraps around to take the head value
      CELL_ROT_LEFT:  if (occ) data <= back ? wrap_data : right_data;
      CELL_ROT_RIGHT: if (occ) data <= left_data;
      default:        data <= data;
    endcase
  end

endmodule

[hdl/double_ended_queue_top.sv]
// Top level of the double-ended queue built as a row of shifting cells.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_item  (mode, value)
//   out     | output    | out_valid/out_stall| out_item (data_out, position, status, last)
//
// Clear, push, pop and refused items each give one result.
// A walk over N entries first takes the item, then rotates the row N places, one place
// per cycle unless a stalled output holds it, emitting one entry per place for the first 32.
// No new item is taken until a walk has brought the row back to its order.
// Reset (rst, synchronous) empties the deque; entry data is not cleared.
// A stalled output holds its result and stops the walk and the input.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   step, step_next;
  logic [CW-1:0]   limit, limit_next;
  logic            walk_rev, walk_rev_next;

  logic            adv, accept, emit, go, produce;
  logic [CW-1:0]   sp1, walk_n;
  out_item_t       result;
  cell_ctrl_t      ctrl;
  word_t           head_in, back_data;

  word_t           cell_data [DEPTH];
  logic            cell_occ  [DEPTH];
  logic            cell_back [DEPTH];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !adv;
  assign accept   = in_valid && !in_stall;
  assign sp1      = step + CW'(1);
  assign emit     = step < limit;
  assign go       = !emit || adv;
  assign walk_n   = (int'(count) > MAX_RESULTS) ? CW'(MAX_RESULTS) : count;

  // Cell row
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_t ld, rd;
      logic  lo, ro;
      if (i == 0) begin : g_first
        assign ld = head_in;
        assign lo = 1'b1;
      end else begin : g_mid
        assign ld = cell_data[i-1];
        assign lo = cell_occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
        assign rd = '0;
        assign ro = 1'b0;
      end else begin : g_inner
        assign rd = cell_data[i+1];
        assign ro = cell_occ[i+1];
      end
      deq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .head       (i == 0),
        .ctrl       (ctrl),
        .left_data  (ld),
        .left_occ   (lo),
        .right_data (rd),
        .right_occ  (ro),
        .wrap_data  (cell_data[0]),
        .data       (cell_data[i]),
        .occ        (cell_occ[i]),
        .back       (cell_back[i])
      );
    end
  endgenerate

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | (cell_data[i] & {DATA_W{cell_back[i]}});
    end
  end

  assign head_in = (ctrl.op == CELL_ROT_RIGHT) ? back_data : in_item.value;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && count != '0 &&
            (in_item.mode == MODE_WALK_FWD || in_item.mode == MODE_WALK_REV)) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (go && sp1 == count) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Cell control, result and counters
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.value    = in_item.value;
    produce       = 1'b0;
    result        = '0;
    result.status = STAT_OK;
    result.last   = 1'b1;
    count_next    = count;
    step_next     = step;
    limit_next    = limit;
    walk_rev_next = walk_rev;
    case (state)
      S_IDLE: begin
        if (accept) begin
          produce = 1'b1;
          case (in_item.mode)
            MODE_CLEAR_STORE: begin
              ctrl.op    = CELL_LOAD;
              count_next = CW'(1);
            end
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (count == '0) begin
                result.status = STAT_EMPTY;
              end else if (int'(count) >= DEPTH) begin
                result.status = STAT_FULL;
              end else begin
                ctrl.op    = (in_item.mode == MODE_PUSH_FRONT) ? CELL_INSERT : CELL_APPEND;
                count_next = count + CW'(1);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (count == '0) begin
                result.status = STAT_EMPTY;
              end else begin
                ctrl.op         = (in_item.mode == MODE_POP_FRONT) ? CELL_REMOVE : CELL_TRIM;
                result.data_out = (in_item.mode == MODE_POP_FRONT) ? cell_data[0] : back_data;
                count_next      = count - CW'(1);
              end
            end
            MODE_WALK_FWD, MODE_WALK_REV: begin
              if (count == '0) begin
                result.status = STAT_EMPTY;
              end else begin
                produce       = 1'b0;
                step_next     = '0;
                limit_next    = walk_n;
                walk_rev_next = (in_item.mode == MODE_WALK_REV);
              end
            end
            default: result.status = STAT_EMPTY;
          endcase
        end
      end
      S_WALK: begin
        if (go) begin
          ctrl.op         = walk_rev ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
          produce         = emit;
          result.data_out = walk_rev ? back_data : cell_data[0];
          result.position = POS_W'(sp1);
          result.last     = (sp1 == limit);
          step_next       = sp1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      limit     <= '0;
      walk_rev  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      step     <= step_next;
      limit    <= limit_next;
      walk_rev <= walk_rev_next;
      if (adv) out_valid <= produce;
    end
  end

  // Hold the result while the far side stalls
  always_ff @(posedge clk) begin
    if (adv && produce) out_item <= result;
  end

endmodule

[hdl/deq_check.sv]
// Port checker for the double-ended queue, bound to the top level.
module deq_check
  import deq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_refused_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != STAT_OK |-> out_item.last)
    else $error("refused item not marked last");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != STAT_OK |->
      out_item.position == '0 && out_item.data_out == '0)
    else $error("refused item carries data");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.position == '0 |-> out_item.last)
    else $error("single transfer not marked last");

endmodule

bind double_ended_queue_top deq_check u_deq_check (.*);
